### rtl/gfse_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the first-set engine
package gfse_pkg;

	localparam int SYM_W     = 6;
	localparam int SET_W     = 64;
	localparam int SET_DEPTH = 2 ** SYM_W;

	localparam int NUM_SYMBOLS_DEF     = 64;
	localparam int MAX_PRODUCTIONS_DEF = 64;
	localparam int MAX_PROD_LEN_DEF    = 8;

	// command codes of an input beat
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_COMPUTE = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROD,
		ST_HEAD,
		ST_ACC,
		ST_SYM,
		ST_SET,
		ST_WB,
		ST_SCAN,
		ST_FETCH,
		ST_SEND
	} state_t;

	// request bundle towards the set store
	typedef struct packed {
		logic             clr;
		logic             rd_en;
		logic [SYM_W-1:0] rd_addr;
		logic             wr_en;
		logic [SYM_W-1:0] wr_addr;
		logic [SET_W-1:0] wr_data;
	} set_req_t;

	function automatic logic [SET_W-1:0] sym_bit(input logic [SYM_W-1:0] s);
		sym_bit = SET_W'(1) << s;
	endfunction

endpackage

### rtl/gfse_in_if.sv
`timescale 1ns / 1ps
// input channel of the first-set engine
interface gfse_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [5:0] head;
	logic [5:0] symbol;
	logic       end_of_production;

	modport source (
		output valid, command, head, symbol, end_of_production,
		input  ready
	);
	modport sink (
		input  valid, command, head, symbol, end_of_production,
		output ready
	);
endinterface

### rtl/gfse_out_if.sv
`timescale 1ns / 1ps
// result channel of the first-set engine
interface gfse_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  nonterminal;
	logic [63:0] first_set;
	logic        last;
	logic        overflow;

	modport source (
		output valid, nonterminal, first_set, last, overflow,
		input  ready
	);
	modport sink (
		input  valid, nonterminal, first_set, last, overflow,
		output ready
	);
endinterface

### rtl/gfse_set_store.sv
`timescale 1ns / 1ps
// first-set store: one set per symbol, registered read, per-entry valid bits
module gfse_set_store (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gfse_pkg::set_req_t       req,
	output logic [gfse_pkg::SET_W-1:0] rd_data
);
	import gfse_pkg::*;

	logic [SET_W-1:0]     mem [SET_DEPTH];
	logic [SET_DEPTH-1:0] valid_q;
	logic [SET_W-1:0]     data_q;
	logic                 hit_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			data_q <= mem[req.rd_addr];
		end
	end

	// entries never written since the last clear read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				hit_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = hit_q ? data_q : '0;

endmodule

### rtl/grammar_first_set_engine_top.sv
`timescale 1ns / 1ps
// top level of the first-set engine: grammar store, sequencer and result port
//
// Loads one production symbol per beat: a load or clear beat is taken while idle
// and the next beat may follow straight away. A compute beat starts a fixed-point
// sequencer that walks all committed productions, pass after pass, until a pass
// changes no set. Every production reads its info and its head's set, then examines
// its symbols, a terminal by a symbol memory read and a nonterminal by a symbol
// memory read, then a set store read, the walk stopping at the first terminal or
// at the first nonterminal without epsilon, and ends in a write-back. After the last
// pass the symbol indexes are scanned one per cycle, pausing at each nonterminal,
// up to the last nonterminal or across all of them when none is stored, each
// nonterminal's set being fetched from the set store and held as a result beat until
// the sink accepts it. The set store has a single read port and the single merge
// unit (or, compare) is shared by all steps, so these steps run one after another.
// No input beat is taken during a compute.
// Loads beyond the production store or beyond the production length are
// dropped and raise the overflow flag, reported on every result beat.
// The epsilon register may only be written while the engine is idle.
module grammar_first_set_engine_top #(
	parameter int NUM_SYMBOLS     = gfse_pkg::NUM_SYMBOLS_DEF,
	parameter int MAX_PRODUCTIONS = gfse_pkg::MAX_PRODUCTIONS_DEF,
	parameter int MAX_PROD_LEN    = gfse_pkg::MAX_PROD_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [gfse_pkg::SYM_W-1:0] cfg_wdata,
	gfse_in_if.sink                    items,
	gfse_out_if.source                 results
);
	import gfse_pkg::*;

	localparam int PW     = $clog2(MAX_PRODUCTIONS);
	localparam int CW     = PW + 1;
	localparam int LW     = $clog2(MAX_PROD_LEN);
	localparam int LENW   = $clog2(MAX_PROD_LEN + 1);
	localparam int SA_W   = PW + LW;
	localparam int INFO_W = SYM_W + LENW;
	localparam int SCAN_W = SYM_W + 1;

	// control state
	state_t             state_q, state_d;
	logic [CW-1:0]      count_q;
	logic [LENW-1:0]    fill_q;
	logic [SET_W-1:0]   head_map_q;
	logic               ovf_q;
	logic [SYM_W-1:0]   eps_q;
	logic [CW-1:0]      p_q;
	logic               changed_q;
	logic [SCAN_W-1:0]  scan_q;
	logic               out_valid_q;

	// working registers of one production
	logic [SET_W-1:0]   acc_q;
	logic [SET_W-1:0]   old_q;
	logic               all_eps_q;
	logic [LW-1:0]      k_q;

	// result payload
	logic [SYM_W-1:0]   out_nt_q;
	logic [SET_W-1:0]   out_set_q;
	logic               out_last_q;
	logic               out_ovf_q;

	// production memories
	logic [SYM_W-1:0]   sym_mem  [2 ** SA_W];
	logic [INFO_W-1:0]  info_mem [2 ** PW];
	logic [SYM_W-1:0]   sym_rd_q;
	logic [INFO_W-1:0]  info_rd_q;

	logic               sym_rd_en;
	logic [SA_W-1:0]    sym_rd_addr;
	logic               info_rd_en;

	set_req_t           set_req;
	logic [SET_W-1:0]   fs_rd;

	logic               accept_in;
	logic               accept_out;
	logic               head_ok;
	logic               sym_ok;
	logic               do_load;
	logic               count_full;
	logic               fill_room;
	logic [LENW-1:0]    fill_after;
	logic               sym_we;
	logic [SA_W-1:0]    sym_waddr;
	logic               info_we;
	logic [SYM_W-1:0]   info_head;
	logic [LENW-1:0]    info_len;
	logic               cur_is_nt;
	logic [SET_W-1:0]   eps_bit;
	logic               fs_has_eps;
	logic               k_last;
	logic [SET_W-1:0]   merge_op;
	logic [SET_W-1:0]   acc_merged;
	logic               differs;
	logic               p_done;
	logic               scan_end;
	logic               scan_hit;
	logic [SET_W-1:0]   scan_hi;
	logic               scan_last;

	assign accept_in  = items.valid && items.ready;
	assign accept_out = results.valid && results.ready;

	// load path
	assign head_ok    = {1'b0, items.head} < SCAN_W'(NUM_SYMBOLS);
	assign sym_ok     = {1'b0, items.symbol} < SCAN_W'(NUM_SYMBOLS);
	assign do_load    = accept_in && (items.command == CMD_LOAD) && head_ok && sym_ok;
	assign count_full = count_q >= CW'(MAX_PRODUCTIONS);
	assign fill_room  = fill_q < LENW'(MAX_PROD_LEN);
	assign fill_after = fill_room ? fill_q + LENW'(1) : fill_q;
	assign sym_we     = do_load && !count_full && fill_room;
	assign sym_waddr  = {count_q[PW-1:0], fill_q[LW-1:0]};
	assign info_we    = do_load && !count_full && items.end_of_production;

	// fixed-point walk
	assign info_head  = info_rd_q[INFO_W-1:LENW];
	assign info_len   = info_rd_q[LENW-1:0];
	assign cur_is_nt  = head_map_q[sym_rd_q];
	assign eps_bit    = sym_bit(eps_q);
	assign fs_has_eps = fs_rd[eps_q];
	assign k_last     = (LENW'(k_q) + LENW'(1)) == info_len;
	assign p_done     = p_q == count_q;

	// shared merge unit: one operand per step, or-ed into the accumulator
	always_comb begin
		case (state_q)
			ST_SYM:  merge_op = sym_bit(sym_rd_q);
			ST_SET:  merge_op = fs_rd & ~eps_bit;
			ST_WB:   merge_op = all_eps_q ? eps_bit : '0;
			default: merge_op = '0;
		endcase
	end

	assign acc_merged = acc_q | merge_op;
	assign differs    = acc_merged != old_q;

	// result scan
	assign scan_end  = scan_q == SCAN_W'(NUM_SYMBOLS);
	assign scan_hit  = head_map_q[scan_q[SYM_W-1:0]];
	assign scan_hi   = head_map_q >> scan_q[SYM_W-1:0];
	assign scan_last = scan_hi[SET_W-1:1] == '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_in && (items.command == CMD_COMPUTE)) begin
					state_d = ST_PROD;
				end
			end
			ST_PROD: begin
				if (!p_done) begin
					state_d = ST_HEAD;
				end else if (!changed_q) begin
					state_d = ST_SCAN;
				end
			end
			ST_HEAD: state_d = ST_ACC;
			ST_ACC: begin
				state_d = (info_len == '0) ? ST_WB : ST_SYM;
			end
			ST_SYM: begin
				state_d = cur_is_nt ? ST_SET : ST_WB;
			end
			ST_SET: begin
				state_d = (!fs_has_eps || k_last) ? ST_WB : ST_SYM;
			end
			ST_WB: state_d = ST_PROD;
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_IDLE;
				end else if (scan_hit) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_SEND;
			ST_SEND: begin
				if (accept_out) begin
					state_d = out_last_q ? ST_IDLE : ST_SCAN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory and store requests
	always_comb begin
		items.ready     = 1'b0;
		info_rd_en      = 1'b0;
		sym_rd_en       = 1'b0;
		sym_rd_addr     = {p_q[PW-1:0], LW'(0)};
		set_req         = '0;
		set_req.wr_addr = info_head;
		set_req.wr_data = acc_merged;
		case (state_q)
			ST_IDLE: begin
				items.ready = 1'b1;
				set_req.clr = accept_in && ((items.command == CMD_COMPUTE)
					|| (items.command == CMD_CLEAR));
			end
			ST_PROD: info_rd_en = !p_done;
			ST_HEAD: begin
				set_req.rd_en   = 1'b1;
				set_req.rd_addr = info_head;
			end
			ST_ACC: sym_rd_en = info_len != '0;
			ST_SYM: begin
				set_req.rd_en   = cur_is_nt;
				set_req.rd_addr = sym_rd_q;
			end
			ST_SET: begin
				sym_rd_en   = fs_has_eps && !k_last;
				sym_rd_addr = {p_q[PW-1:0], k_q + LW'(1)};
			end
			ST_WB: set_req.wr_en = differs;
			ST_SCAN: begin
				set_req.rd_en   = !scan_end && scan_hit;
				set_req.rd_addr = scan_q[SYM_W-1:0];
			end
			default: ;
		endcase
	end

	// production memories
	always_ff @(posedge clk) begin
		if (sym_we) begin
			sym_mem[sym_waddr] <= items.symbol;
		end
		if (sym_rd_en) begin
			sym_rd_q <= sym_mem[sym_rd_addr];
		end
		if (info_we) begin
			info_mem[count_q[PW-1:0]] <= {items.head, fill_after};
		end
		if (info_rd_en) begin
			info_rd_q <= info_mem[p_q[PW-1:0]];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			fill_q      <= '0;
			head_map_q  <= '0;
			ovf_q       <= 1'b0;
			eps_q       <= '0;
			p_q         <= '0;
			changed_q   <= 1'b0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				eps_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (do_load) begin
						if (count_full || !fill_room) begin
							ovf_q <= 1'b1;
						end
						if (!count_full) begin
							if (items.end_of_production) begin
								head_map_q[items.head] <= 1'b1;
								count_q                <= count_q + CW'(1);
								fill_q                 <= '0;
							end else begin
								fill_q <= fill_after;
							end
						end
					end else if (accept_in && (items.command == CMD_CLEAR)) begin
						count_q    <= '0;
						fill_q     <= '0;
						head_map_q <= '0;
						ovf_q      <= 1'b0;
					end else if (accept_in && (items.command == CMD_COMPUTE)) begin
						p_q       <= '0;
						changed_q <= 1'b0;
					end
				end
				ST_PROD: begin
					if (p_done) begin
						p_q       <= '0;
						changed_q <= 1'b0;
						scan_q    <= '0;
					end
				end
				ST_WB: begin
					if (differs) begin
						changed_q <= 1'b1;
					end
					p_q <= p_q + CW'(1);
				end
				ST_SCAN: begin
					if (!scan_end && !scan_hit) begin
						scan_q <= scan_q + SCAN_W'(1);
					end
				end
				ST_FETCH: out_valid_q <= 1'b1;
				ST_SEND: begin
					if (accept_out) begin
						out_valid_q <= 1'b0;
						scan_q      <= scan_q + SCAN_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// working and payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_ACC: begin
				acc_q     <= fs_rd;
				old_q     <= fs_rd;
				all_eps_q <= 1'b1;
				k_q       <= '0;
			end
			ST_SYM: begin
				if (!cur_is_nt) begin
					acc_q     <= acc_merged;
					all_eps_q <= 1'b0;
				end
			end
			ST_SET: begin
				acc_q <= acc_merged;
				if (!fs_has_eps) begin
					all_eps_q <= 1'b0;
				end else if (!k_last) begin
					k_q <= k_q + LW'(1);
				end
			end
			ST_FETCH: begin
				out_nt_q   <= scan_q[SYM_W-1:0];
				out_set_q  <= fs_rd;
				out_last_q <= scan_last;
				out_ovf_q  <= ovf_q;
			end
			default: ;
		endcase
	end

	gfse_set_store u_set_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (set_req),
		.rd_data (fs_rd)
	);

	assign results.valid       = out_valid_q;
	assign results.nonterminal = out_nt_q;
	assign results.first_set   = out_set_q;
	assign results.last        = out_last_q;
	assign results.overflow    = out_ovf_q;

	// a result beat never waits while new input is taken
	a_ready_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		items.ready |-> !out_valid_q)
		else $error("input taken while a result beat is pending");

	// sets are written back only at the end of a production
	a_store_write_wb: assert property (@(posedge clk) disable iff (!arst_n)
		set_req.wr_en |-> (state_q == ST_WB))
		else $error("set store written outside write-back");

	// reported symbol heads a committed production
	a_result_is_nt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> head_map_q[out_nt_q])
		else $error("result for a symbol that heads no production");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_PRODUCTIONS))
		else $error("production count beyond store capacity");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LENW'(MAX_PROD_LEN))
		else $error("fill position beyond production length");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench of the first-set engine: a directed table, then random grammars
module tb_top;
	import gfse_pkg::*;

	// command code the engine must ignore
	localparam logic [1:0] CMD_RSVD = 2'd3;

	localparam int MAXP          = MAX_PRODUCTIONS_DEF;
	localparam int MAXL          = MAX_PROD_LEN_DEF;
	localparam int ITEM_TARGET   = 420;
	localparam int IDLE_PCT      = 12;
	// covers the tail of a compute that reports nothing: a scan across every symbol index
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic [5:0]  nonterminal;
		logic [63:0] first_set;
		logic        last;
		logic        overflow;
	} set_beat_t;

	// how a directed row is checked
	typedef enum logic [1:0] {
		BY_MODEL,
		NO_BEAT,
		ONE_BEAT
	} row_check_t;

	typedef struct packed {
		logic [1:0] command;
		logic [5:0] head;
		logic [5:0] symbol;
		logic       eop;
		row_check_t check;
		set_beat_t  want;
	} drill_row_t;

	// directed part, epsilon at its reset value 0
	localparam drill_row_t DRILL [26] = '{
		// compute straight after reset: nothing stored, nothing reported
		'{CMD_COMPUTE, 6'd0, 6'd0, 1'b0, NO_BEAT, '0},
		// reserved command is ignored
		'{CMD_RSVD, 6'd63, 6'd63, 1'b1, NO_BEAT, '0},
		// 1 -> 5
		'{CMD_LOAD, 6'd1, 6'd5, 1'b1, BY_MODEL, '0},
		'{CMD_COMPUTE, 6'd0, 6'd0, 1'b0, ONE_BEAT, '{6'd1, 64'h20, 1'b1, 1'b0}},
		// unfinished production stays invisible to a compute
		'{CMD_LOAD, 6'd2, 6'd9, 1'b0, BY_MODEL, '0},
		'{CMD_COMPUTE, 6'd63, 6'd63, 1'b1, ONE_BEAT, '{6'd1, 64'h20, 1'b1, 1'b0}},
		// the head on the ending beat wins: 3 -> 9 0
		'{CMD_LOAD, 6'd3, 6'd0, 1'b1, BY_MODEL, '0},
		// epsilon index as a plain terminal: 4 -> 0
		'{CMD_LOAD, 6'd4, 6'd0, 1'b1, BY_MODEL, '0},
		// 63 -> 4 63 1, left recursion through an epsilon-deriving nonterminal
		'{CMD_LOAD, 6'd63, 6'd4, 1'b0, BY_MODEL, '0},
		'{CMD_LOAD, 6'd63, 6'd63, 1'b0, BY_MODEL, '0},
		'{CMD_LOAD, 6'd63, 6'd1, 1'b1, BY_MODEL, '0},
		'{CMD_COMPUTE, 6'd0, 6'd0, 1'b0, BY_MODEL, '0},
		// clear, then a compute with no nonterminals
		'{CMD_CLEAR, 6'd0, 6'd0, 1'b0, NO_BEAT, '0},
		'{CMD_COMPUTE, 6'd0, 6'd0, 1'b0, NO_BEAT, '0},
		// nine symbols into an eight-symbol production: the last is dropped, flag raised
		'{CMD_LOAD, 6'd5, 6'd10, 1'b0, BY_MODEL, '0},
		'{CMD_LOAD, 6'd5, 6'd11, 1'b0, BY_MODEL, '0},
		'{CMD_LOAD, 6'd5, 6'd12, 1'b0, BY_MODEL, '0},
		'{CMD_LOAD, 6'd5, 6'd13, 1'b0, BY_MODEL, '0},
		'{CMD_LOAD, 6'd5, 6'd14, 1'b0, BY_MODEL, '0},
		'{CMD_LOAD, 6'd5, 6'd15, 1'b0, BY_MODEL, '0},
		'{CMD_LOAD, 6'd5, 6'd16, 1'b0, BY_MODEL, '0},
		'{CMD_LOAD, 6'd5, 6'd17, 1'b0, BY_MODEL, '0},
		'{CMD_LOAD, 6'd5, 6'd18, 1'b1, BY_MODEL, '0},
		'{CMD_COMPUTE, 6'd0, 6'd0, 1'b0, ONE_BEAT, '{6'd5, 64'h400, 1'b1, 1'b1}},
		// clear drops the overflow flag along with the store
		'{CMD_CLEAR, 6'd63, 6'd63, 1'b1, NO_BEAT, '0},
		'{CMD_COMPUTE, 6'd0, 6'd0, 1'b0, NO_BEAT, '0}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [5:0] cfg_wdata;

	gfse_in_if  items_if ();
	gfse_out_if results_if ();

	grammar_first_set_engine_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (items_if),
		.results   (results_if)
	);

	always #5 clk = ~clk;

	// own copy of the grammar store and of the sets
	logic [5:0]  rhs_store [MAXP*MAXL];
	logic [5:0]  head_store [MAXP];
	int unsigned len_store [MAXP];
	int unsigned committed;
	int unsigned fill_pos;
	logic [63:0] nt_map;
	logic [63:0] first_of [64];
	logic        ovf_seen;
	logic [5:0]  eps_sym;

	set_beat_t   step_beats [$];    // beats caused by the beat just accepted
	set_beat_t   pending_sets [$];  // result beats still owed by the engine

	// symbols a random grammar draws its nonterminals from
	logic [5:0]  nt_pool [8];
	int unsigned pool_size;

	int unsigned mismatches = 0;
	int unsigned beats_in = 0;
	int unsigned beats_out = 0;
	int unsigned computes = 0;
	int unsigned eps_writes = 0;
	bit          steady = 1'b0;        // no idling on either side
	bit          hold_request = 1'b0;  // asks the result side for a long hold-off

	function automatic void grammar_clear();
		committed = 0;
		fill_pos  = 0;
		nt_map    = '0;
		ovf_seen  = 1'b0;
		foreach (first_of[i])
			first_of[i] = '0;
	endfunction

	function automatic void grammar_load(logic [5:0] h, logic [5:0] s, logic e);
		if (committed >= MAXP) begin
			ovf_seen = 1'b1;
			return;
		end
		head_store[committed] = h;
		if (fill_pos < MAXL) begin
			rhs_store[committed*MAXL + fill_pos] = s;
			fill_pos++;
		end else begin
			ovf_seen = 1'b1;
		end
		if (e) begin
			len_store[committed] = fill_pos;
			nt_map[h] = 1'b1;
			committed++;
			fill_pos = 0;
		end
	endfunction

	// iterate over the committed productions until no set changes
	function automatic void solve_first_sets();
		logic [63:0] eps_bit;
		logic [63:0] acc;
		logic        changed;
		logic        all_eps;
		logic [5:0]  h;
		logic [5:0]  s;
		int unsigned p;
		int unsigned k;
		eps_bit = 64'd1 << eps_sym;
		foreach (first_of[i])
			first_of[i] = '0;
		changed = 1'b1;
		while (changed) begin
			changed = 1'b0;
			for (p = 0; p < committed; p++) begin
				h = head_store[p];
				acc = first_of[h];
				all_eps = 1'b1;
				for (k = 0; k < len_store[p]; k++) begin
					s = rhs_store[p*MAXL + k];
					if (!nt_map[s]) begin
						acc |= 64'd1 << s;
						all_eps = 1'b0;
						break;
					end
					acc |= first_of[s] & ~eps_bit;
					if ((first_of[s] & eps_bit) == '0) begin
						all_eps = 1'b0;
						break;
					end
				end
				if (all_eps)
					acc |= eps_bit;
				if (acc != first_of[h]) begin
					first_of[h] = acc;
					changed = 1'b1;
				end
			end
		end
	endfunction

	function automatic void grammar_apply(logic [1:0] cmd, logic [5:0] h, logic [5:0] s,
			logic e);
		step_beats.delete();
		case (cmd)
			CMD_LOAD: begin
				grammar_load(h, s, e);
			end
			CMD_COMPUTE: begin
				solve_first_sets();
				for (int i = 0; i < 64; i++)
					if (nt_map[i])
						step_beats.push_back('{6'(i), first_of[i], 1'b0, ovf_seen});
				if (step_beats.size() != 0)
					step_beats[step_beats.size()-1].last = 1'b1;
			end
			CMD_CLEAR: begin
				grammar_clear();
			end
			default: ;
		endcase
	endfunction

	function automatic logic [5:0] pick_symbol();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return nt_pool[$urandom_range(pool_size-1)];
		if (r < 65)
			return eps_sym;
		return 6'($urandom);
	endfunction

	function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// offer one beat, wait for the handshake, then book what it owes
	task automatic send_beat(logic [1:0] cmd, logic [5:0] h, logic [5:0] s, logic e,
			row_check_t chk = BY_MODEL, set_beat_t want = '0);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.valid             <= 1'b1;
		items_if.command           <= cmd;
		items_if.head              <= h;
		items_if.symbol            <= s;
		items_if.end_of_production <= e;
		@(posedge clk);
		while (!items_if.ready)
			@(posedge clk);
		grammar_apply(cmd, h, s, e);
		if (chk == BY_MODEL) begin
			foreach (step_beats[i])
				pending_sets.push_back(step_beats[i]);
		end else if (chk == ONE_BEAT) begin
			pending_sets.push_back(want);
		end
		if (cmd == CMD_COMPUTE)
			computes++;
		if (cmd != CMD_RSVD)
			beats_in++;
	endtask

	// sender pauses until every owed beat is in, then lets the engine go quiet
	task automatic drain_results();
		items_if.valid <= 1'b0;
		while (pending_sets.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_epsilon(logic [5:0] v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		eps_sym = v;
		eps_writes++;
	endtask

	// one small random grammar, loaded symbol by symbol, then computed
	task automatic grammar_phase(int unsigned n_prods, int unsigned long_pct, bit hold);
		int unsigned p;
		int unsigned k;
		int unsigned len;
		logic [5:0]  h;
		pool_size = $urandom_range(1, 8);
		for (k = 0; k < pool_size; k++)
			nt_pool[k] = ($urandom_range(9) == 0) ? eps_sym : 6'($urandom);
		// now and then keep the old grammar, so the store can fill up over phases
		if ($urandom_range(9) < 8)
			send_beat(CMD_CLEAR, 6'($urandom), 6'($urandom), 1'($urandom));
		for (p = 0; p < n_prods; p++) begin
			h = nt_pool[$urandom_range(pool_size-1)];
			len = ($urandom_range(99) < long_pct) ? $urandom_range(9, 11) : $urandom_range(1, 4);
			// early beats may carry a stray head, only the ending one counts
			for (k = 0; k < len; k++)
				send_beat(CMD_LOAD, (k + 1 == len || $urandom_range(4) != 0) ? h : 6'($urandom),
					pick_symbol(), k + 1 == len);
			if ($urandom_range(19) == 0)
				send_beat(CMD_RSVD, 6'($urandom), 6'($urandom), 1'($urandom));
		end
		// a dangling production start that must not show in this compute
		if ($urandom_range(4) == 0)
			send_beat(CMD_LOAD, 6'($urandom), pick_symbol(), 1'b0);
		if (hold)
			hold_request = 1'b1;
		send_beat(CMD_COMPUTE, 6'($urandom), 6'($urandom), 1'($urandom));
		// a second compute has to start afresh and give the same sets
		if ($urandom_range(3) == 0)
			send_beat(CMD_COMPUTE, 6'($urandom), 6'($urandom), 1'($urandom));
	endtask

	// fill every production slot, with every index heading one, then overrun the store
	task automatic fill_store_phase();
		int unsigned k;
		send_beat(CMD_CLEAR, 6'($urandom), 6'($urandom), 1'($urandom));
		for (k = 0; k < MAXP + 6; k++)
			send_beat(CMD_LOAD, 6'(k), 6'($urandom), (k < MAXP) ? 1'b1 : 1'($urandom));
		send_beat(CMD_COMPUTE, 6'($urandom), 6'($urandom), 1'($urandom));
	endtask

	// result side: random back-pressure, one long hold-off on request
	initial begin : result_sink
		int unsigned hold_left;
		set_beat_t   got;
		set_beat_t   want;
		hold_left = 0;
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && results_if.valid && results_if.ready) begin
				got = '{results_if.nonterminal, results_if.first_set, results_if.last,
					results_if.overflow};
				beats_out++;
				if (pending_sets.size() == 0) begin
					$display("%0t: result beat with none expected, got %h", $time, got);
					mismatches++;
				end else begin
					want = pending_sets.pop_front();
					check_field("nonterminal", 64'(want.nonterminal), 64'(got.nonterminal));
					check_field("first_set", want.first_set, got.first_set);
					check_field("last", 64'(want.last), 64'(got.last));
					check_field("overflow", 64'(want.overflow), 64'(got.overflow));
				end
			end
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin : stimulus
		int unsigned phase;
		logic [5:0]  eps_next;
		arst_n                     <= 1'b0;
		cfg_we                     <= 1'b0;
		cfg_wdata                  <= '0;
		items_if.valid             <= 1'b0;
		items_if.command           <= CMD_LOAD;
		items_if.head              <= '0;
		items_if.symbol            <= '0;
		items_if.end_of_production <= 1'b0;
		grammar_clear();
		eps_sym = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DRILL[i])
			send_beat(DRILL[i].command, DRILL[i].head, DRILL[i].symbol, DRILL[i].eop,
				DRILL[i].check, DRILL[i].want);

		for (phase = 0; beats_in < ITEM_TARGET; phase++) begin
			// new epsilon every fourth phase: top index, bottom index, then two random ones, in turn
			if (phase % 4 == 0) begin
				case ((phase / 4) % 4)
					0:       eps_next = 6'd63;
					1:       eps_next = 6'd0;
					default: eps_next = 6'($urandom);
				endcase
				write_epsilon(eps_next);
			end
			steady = (phase == 3 || phase == 4);
			if (phase == 9)
				fill_store_phase();
			else
				grammar_phase($urandom_range(3, 12), (phase % 5 == 2) ? 30 : 5, phase == 6);
		end
		steady = 1'b0;

		drain_results();
		$display("%0d input beats, %0d computes, %0d result beats checked", beats_in, computes,
			beats_out);
		$display("%0d epsilon settings, store overrun and long productions included", eps_writes);
		if (mismatches == 0 && pending_sets.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin : watchdog
		#20ms;
		$display("simulation failed");
		$finish;
	end

endmodule
